// ===== design/fsip_pkg.sv =====
// ----------------------------------------------------------------------------
// fsip_pkg: shared types and constants of the integer format engine
// Character codes, field limits, sequencer states and digit helpers.
// ----------------------------------------------------------------------------
package fsip_pkg;

	// field limits
	localparam int FIELD_MAX = 63;
	localparam int FW        = $clog2(FIELD_MAX + 1);
	localparam int DIGITS    = 10;
	localparam int DIG_W     = $clog2(DIGITS);
	localparam int ARG_W     = 32;
	localparam int CNT_W     = $clog2(ARG_W);

	// character codes
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2d;

	// parse modes
	typedef enum logic [1:0] {
		MODE_TEXT  = 2'd0,
		MODE_WIDTH = 2'd1,
		MODE_PREC  = 2'd2
	} mode_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_SPACE,
		ST_MINUS,
		ST_ZERO,
		ST_DIGIT
	} state_t;

	typedef logic [DIGITS-1:0][3:0] digits_t;

	// ascii form of one digit, decimal or lower-case hex
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		if (d < 4'd10)
			digit_char = CH_ZERO + {4'd0, d};
		else
			digit_char = CH_A + {4'd0, d} - 8'd10;
	endfunction

endpackage

// ===== design/fsip_dabble.sv =====
// ----------------------------------------------------------------------------
// fsip_dabble: bit-serial binary to digit converter
// Decimal values shift in one bit per cycle with add-3 correction;
// hex values load their nibbles directly.
// ----------------------------------------------------------------------------
module fsip_dabble (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   is_dec,
	input  logic [31:0]            mag,
	output logic                   done,
	output fsip_pkg::digits_t      digits
);
	import fsip_pkg::*;

	logic [ARG_W-1:0] mag_q;
	digits_t          bcd_q;
	digits_t          adj;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	// add 3 to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				run_q  <= is_dec;
				done_q <= !is_dec;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ARG_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			if (is_dec)
				bcd_q <= '0;
			else
				bcd_q <= digits_t'({{(DIGITS * 4 - ARG_W){1'b0}}, mag});
		end else if (run_q) begin
			mag_q <= {mag_q[ARG_W-2:0], 1'b0};
			bcd_q <= digits_t'({adj[DIGITS-1:0], mag_q[ARG_W-1]} >> 0);
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;

endmodule

// ===== design/format_string_integer_printer.sv =====
// ----------------------------------------------------------------------------
// format_string_integer_printer: printf-style integer format engine
// Echoes text bytes and expands %[width][.prec]d and %[width][.prec]x conversions.
// ----------------------------------------------------------------------------
// Usage
//   Input beats on s_* carry one format byte plus the argument that is used
//   if that byte ends a conversion. Output beats on m_* carry one written
//   character and the running character count; m_tlast marks the final
//   character caused by one input beat.
//   A text byte is echoed in the cycle it is accepted and shows up in the
//   next cycle; '%', width, '.' and precision bytes write nothing. A %d
//   conversion runs the bit-serial binary to decimal converter (shifts,
//   then a done step), then a sizing step, then writes its characters;
//   %x skips the shift loop. The next input beat is taken once the last
//   character of the current one sits in the output register.
//   Reset returns the parser to text mode and clears the count.
//   When the receiver stalls, the output register holds its beat and the
//   input side and the character-writing states of the sequencer wait.
// ----------------------------------------------------------------------------
module format_string_integer_printer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // format_char[7:0], argument[39:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_char[7:0], total_written[39:8]
	output logic        m_tlast
);
	import fsip_pkg::*;

	state_t            state_q, state_d;
	mode_t             mode_q;
	logic [FW-1:0]     fw_q;
	logic              hasp_q;
	logic [FW-1:0]     prec_q;
	logic              neg_q;
	logic [FW-1:0]     spc_q;
	logic [FW-1:0]     zer_q;
	logic [DIG_W-1:0]  dig_q;
	logic [ARG_W-1:0]  count_q;
	logic              ovalid_q;
	logic [7:0]        ochar_q;
	logic              olast_q;

	logic [7:0]        in_char;
	logic [ARG_W-1:0]  in_arg;
	logic              accept;
	logic              slot;
	logic              is_digit;
	logic [3:0]        in_digit;
	logic [9:0]        acc_w;
	logic [9:0]        acc_p;
	logic              conv;
	logic              conv_dec;
	logic              neg_in;
	logic [ARG_W-1:0]  mag_in;
	logic              dab_done;
	digits_t           digits;

	logic [DIG_W:0]    nd;
	logic [FW-1:0]     zeros;
	logic [FW:0]       body;
	logic [FW-1:0]     spaces;

	logic              emit;
	logic [7:0]        emit_char;
	logic              emit_last;

	assign in_char  = s_tdata[7:0];
	assign in_arg   = s_tdata[39:8];
	assign slot     = !ovalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && slot;
	assign accept   = s_tvalid && s_tready;

	// width and precision digit accumulation
	assign is_digit = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
	assign in_digit = 4'(in_char - CH_ZERO);
	assign acc_w = ({{(10 - FW){1'b0}}, fw_q} << 3) + ({{(10 - FW){1'b0}}, fw_q} << 1)
		+ {6'd0, in_digit};
	assign acc_p = ({{(10 - FW){1'b0}}, prec_q} << 3) + ({{(10 - FW){1'b0}}, prec_q} << 1)
		+ {6'd0, in_digit};

	// conversion decode
	assign conv     = (mode_q != MODE_TEXT) && !is_digit
		&& !((in_char == CH_DOT) && (mode_q == MODE_WIDTH))
		&& ((in_char == CH_D) || (in_char == CH_X));
	assign conv_dec = (in_char == CH_D);
	assign neg_in   = conv_dec && in_arg[ARG_W-1];
	assign mag_in   = neg_in ? (~in_arg + 1'b1) : in_arg;

	fsip_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && conv),
		.is_dec (conv_dec),
		.mag    (mag_in),
		.done   (dab_done),
		.digits (digits)
	);

	// layout: digit count, zero padding, space padding
	always_comb begin
		nd = (DIG_W + 1)'(1);
		for (int i = 1; i < DIGITS; i++) begin
			if (digits[i] != 4'd0)
				nd = (DIG_W + 1)'(i + 1);
		end
		zeros = '0;
		if (hasp_q && ({1'b0, prec_q} > {{(FW - DIG_W){1'b0}}, nd}))
			zeros = prec_q - FW'(nd);
		body = {1'b0, zeros} + {{(FW - DIG_W){1'b0}}, nd} + {{FW{1'b0}}, neg_q};
		spaces = '0;
		if ({1'b0, fw_q} > body)
			spaces = fw_q - body[FW-1:0];
	end

	// next state and character emission
	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_char = CH_SPACE;
		emit_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode_q == MODE_TEXT) begin
						if (in_char != CH_PCT) begin
							emit      = 1'b1;
							emit_char = in_char;
							emit_last = 1'b1;
						end
					end else if (conv) begin
						state_d = ST_CONV;
					end
				end
			end
			ST_CONV: begin
				if (dab_done)
					state_d = ST_SIZE;
			end
			ST_SIZE: begin
				if (spaces != '0)
					state_d = ST_SPACE;
				else if (neg_q)
					state_d = ST_MINUS;
				else if (zeros != '0)
					state_d = ST_ZERO;
				else
					state_d = ST_DIGIT;
			end
			ST_SPACE: begin
				if (slot) begin
					emit      = 1'b1;
					emit_char = CH_SPACE;
					if (spc_q == FW'(1)) begin
						if (neg_q)
							state_d = ST_MINUS;
						else if (zer_q != '0)
							state_d = ST_ZERO;
						else
							state_d = ST_DIGIT;
					end
				end
			end
			ST_MINUS: begin
				if (slot) begin
					emit      = 1'b1;
					emit_char = CH_MINUS;
					state_d   = (zer_q != '0) ? ST_ZERO : ST_DIGIT;
				end
			end
			ST_ZERO: begin
				if (slot) begin
					emit      = 1'b1;
					emit_char = CH_ZERO;
					if (zer_q == FW'(1))
						state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (slot) begin
					emit      = 1'b1;
					emit_char = digit_char(digits[dig_q]);
					if (dig_q == '0) begin
						emit_last = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_TEXT;
			fw_q    <= '0;
			hasp_q  <= 1'b0;
			prec_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (emit)
				count_q <= count_q + 1'b1;
			if (accept) begin
				if (mode_q == MODE_TEXT) begin
					if (in_char == CH_PCT) begin
						mode_q <= MODE_WIDTH;
						fw_q   <= '0;
						hasp_q <= 1'b0;
						prec_q <= '0;
					end
				end else if (is_digit) begin
					if (mode_q == MODE_WIDTH)
						fw_q <= (acc_w > 10'(FIELD_MAX)) ? FW'(FIELD_MAX) : acc_w[FW-1:0];
					else
						prec_q <= (acc_p > 10'(FIELD_MAX - 1)) ? FW'(FIELD_MAX - 1)
							: acc_p[FW-1:0];
				end else if ((in_char == CH_DOT) && (mode_q == MODE_WIDTH)) begin
					mode_q <= MODE_PREC;
					hasp_q <= 1'b1;
					prec_q <= '0;
				end else begin
					mode_q <= MODE_TEXT;
				end
			end
		end
	end

	// conversion counters
	always_ff @(posedge clk) begin
		if (accept && conv)
			neg_q <= neg_in;
		if (state_q == ST_SIZE) begin
			spc_q <= spaces;
			zer_q <= zeros;
			dig_q <= DIG_W'(nd - 1'b1);
		end else if (emit) begin
			case (state_q)
				ST_SPACE: spc_q <= spc_q - 1'b1;
				ST_ZERO:  zer_q <= zer_q - 1'b1;
				ST_DIGIT: dig_q <= dig_q - 1'b1;
				default:  ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (emit)
			ovalid_q <= 1'b1;
		else if (m_tready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ochar_q <= emit_char;
			olast_q <= emit_last;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {count_q, ochar_q};
	assign m_tlast  = olast_q;

	// checks
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == ST_IDLE))
		else $error("input taken while a conversion runs");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (count_q == $past(count_q) + 1'b1))
		else $error("character count out of step");

	a_space_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPACE) |-> (spc_q != '0))
		else $error("space padding underflow");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGIT) |-> (dig_q < DIG_W'(DIGITS)))
		else $error("digit index out of range");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream testbench of the integer format engine
// Feeds format bytes with arguments, predicts every written character with
// its last mark and running count, and checks each output beat in order.
// ----------------------------------------------------------------------------
module tb_top;
	import fsip_pkg::*;

	localparam int N_RANDOM    = 250;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 120;

	// one format byte with its argument
	typedef struct packed {
		logic [31:0] arg;
		logic [7:0]  fmt_char;
	} fmt_beat_t;

	// one written character
	typedef struct packed {
		logic [7:0]  ch;
		logic        is_last;
		logic [31:0] total;
	} wr_char_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;   // format_char[7:0], argument[39:8]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // out_char[7:0], total_written[39:8]
	logic        m_tlast;

	fmt_beat_t format_bytes[$];
	wr_char_t  chars_due[$];
	int        errors  = 0;
	int        n_taken = 0;
	int        stall_cycles = 0;

	// predictor state
	mode_t       fmt_mode  = MODE_TEXT;
	logic [5:0]  fld_width = '0;
	logic        has_prec  = 1'b0;
	logic [5:0]  prec      = '0;
	logic [31:0] wr_count  = '0;

	format_string_integer_printer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	// no idling in a middle stretch of the run
	function automatic logic may_idle();
		if (n_taken >= 110 && n_taken < 180)
			return 1'b0;
		return ($urandom_range(99) < 23);
	endfunction

	task automatic put_char(input logic [7:0] c);
		wr_char_t w;
		wr_count  = wr_count + 32'd1;
		w.ch      = c;
		w.is_last = 1'b0;
		w.total   = wr_count;
		chars_due.push_back(w);
	endtask

	// integer conversion: spaces, sign, zeros, digits
	task automatic convert_arg(input logic [31:0] arg, input logic is_dec);
		logic [7:0]  digs[12];
		logic [31:0] mag;
		logic [31:0] base;
		logic [31:0] d;
		logic        neg;
		int          nd;
		int          zeros;
		int          spaces;
		int          body;
		int          i;
		neg    = is_dec && arg[31];
		mag    = neg ? (32'd0 - arg) : arg;
		base   = is_dec ? 32'd10 : 32'd16;
		nd     = 0;
		zeros  = 0;
		spaces = 0;
		do begin
			d = mag % base;
			digs[nd] = (d < 10) ? (CH_ZERO + 8'(d)) : (CH_A + 8'(d) - 8'd10);
			nd++;
			mag = mag / base;
		end while (mag != 0 && nd < 12);
		if (has_prec && int'(prec) > nd)
			zeros = int'(prec) - nd;
		body = zeros + nd + (neg ? 1 : 0);
		if (int'(fld_width) > body)
			spaces = int'(fld_width) - body;
		for (i = 0; i < spaces; i++)
			put_char(CH_SPACE);
		if (neg)
			put_char(CH_MINUS);
		for (i = 0; i < zeros; i++)
			put_char(CH_ZERO);
		for (i = nd - 1; i >= 0; i--)
			put_char(digs[i]);
	endtask

	// advance the parser by one format byte and queue its characters
	task automatic format_byte(input logic [7:0] c, input logic [31:0] arg);
		int n_before;
		int v;
		n_before = chars_due.size();
		if (fmt_mode == MODE_TEXT) begin
			if (c == CH_PCT) begin
				fmt_mode  = MODE_WIDTH;
				fld_width = '0;
				has_prec  = 1'b0;
				prec      = '0;
			end else begin
				put_char(c);
			end
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			if (fmt_mode == MODE_WIDTH) begin
				v = int'(fld_width) * 10 + int'(c - CH_ZERO);
				fld_width = (v > FIELD_MAX) ? 6'(FIELD_MAX) : 6'(v);
			end else begin
				v = int'(prec) * 10 + int'(c - CH_ZERO);
				prec = (v > FIELD_MAX - 1) ? 6'(FIELD_MAX - 1) : 6'(v);
			end
		end else if (c == CH_DOT && fmt_mode == MODE_WIDTH) begin
			fmt_mode = MODE_PREC;
			has_prec = 1'b1;
			prec     = '0;
		end else begin
			fmt_mode = MODE_TEXT;
			if (c == CH_D)
				convert_arg(arg, 1'b1);
			else if (c == CH_X)
				convert_arg(arg, 1'b0);
		end
		if (chars_due.size() > n_before)
			chars_due[chars_due.size() - 1].is_last = 1'b1;
	endtask

	task automatic push_beat(input logic [7:0] c, input logic [31:0] arg);
		fmt_beat_t b;
		b.fmt_char = c;
		b.arg      = arg;
		format_bytes.push_back(b);
	endtask

	// a format string; only its final byte carries the real argument
	task automatic push_text(input string s, input logic [31:0] arg);
		int i;
		for (i = 0; i < s.len(); i++)
			push_beat(s[i], (i == s.len() - 1) ? arg : $urandom);
	endtask

	function automatic logic [31:0] pick_arg();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return 32'h7fff_ffff;
			4: return $urandom_range(99);
			default: return $urandom;
		endcase
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin : drv
		logic      present;
		fmt_beat_t b;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			present = s_tvalid;
			if (s_tvalid && s_tready) begin
				format_byte(s_tdata[7:0], s_tdata[39:8]);
				n_taken <= n_taken + 1;
				present = 1'b0;
			end
			if (!present && format_bytes.size() > 0 && !may_idle()) begin
				b = format_bytes.pop_front();
				s_tdata <= {b.arg, b.fmt_char};
				present = 1'b1;
			end
			s_tvalid <= present;
		end
	end

	// output monitor and checker
	always @(posedge clk or negedge arst_n) begin : mon
		wr_char_t w;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (chars_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, got char %h last %b total %0d",
						$time, m_tdata[7:0], m_tlast, m_tdata[39:8]);
				end else begin
					w = chars_due.pop_front();
					if (m_tdata[7:0] !== w.ch) begin
						errors++;
						$display("%0t: out_char expected %h got %h", $time, w.ch, m_tdata[7:0]);
					end
					if (m_tlast !== w.is_last) begin
						errors++;
						$display("%0t: last expected %b got %b", $time, w.is_last, m_tlast);
					end
					if (m_tdata[39:8] !== w.total) begin
						errors++;
						$display("%0t: total_written expected %0d got %0d",
							$time, w.total, m_tdata[39:8]);
					end
				end
			end
			m_tready <= !may_idle();
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("** format_string_integer_printer: FAILED **");
				$finish;
			end
		end
	end

	// stimulus and end of run
	initial begin : stim
		string spec;
		int    n_directed;
		int    pick;
		int    r;

		// directed: text extremes, unknown conversions, zero, extremes of d and x
		push_text("A", $urandom);
		push_beat(8'h00, 32'h0);
		push_beat(8'hff, 32'hffff_ffff);
		push_text("%%", 32'h1234_5678);
		push_text("%.0d", 32'd0);
		push_text("%d", 32'h8000_0000);
		push_text("%x", 32'hffff_ffff);
		push_text("%99d", 32'd7);
		push_text("%.70x", 32'd0);
		push_text("%9.4d", 32'hffff_fff4);
		push_beat(CH_PCT, $urandom);
		push_beat(8'h00, $urandom);
		n_directed = format_bytes.size();

		// random: mostly well-formed conversions, some plain bytes and broken specs
		while (format_bytes.size() < n_directed + N_RANDOM) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				spec = "%";
				r = $urandom_range(9);
				if (r < 6)
					spec = {spec, $sformatf("%0d", $urandom_range(12))};
				else if (r < 8)
					spec = {spec, $sformatf("%0d", $urandom_range(99))};
				r = $urandom_range(9);
				if (r < 4) begin
					spec = {spec, "."};
					if ($urandom_range(3) != 0)
						spec = {spec, $sformatf("%0d", $urandom_range(12))};
				end else if (r == 4) begin
					spec = {spec, ".", $sformatf("%0d", $urandom_range(99, 40))};
				end
				if ($urandom_range(1))
					spec = {spec, "d"};
				else
					spec = {spec, "x"};
				push_text(spec, pick_arg());
			end else if (pick < 85) begin
				push_beat(8'($urandom), $urandom);
			end else begin
				push_text({"%", $sformatf("%0d", $urandom_range(20))}, $urandom);
				if ($urandom_range(1))
					push_beat(CH_DOT, $urandom);
				push_beat(8'($urandom), $urandom);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (format_bytes.size() != 0 || s_tvalid)
			@(posedge clk);
		while (chars_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("** format_string_integer_printer: PASSED **");
		else
			$display("** format_string_integer_printer: FAILED **");
		$finish;
	end

endmodule
